[rtl/hfsc_pkg.sv]
// ----------------------------------------------------------------------------
// hfsc_pkg
// shared types, codes and signature tables for the header/footer carver
// ----------------------------------------------------------------------------
package hfsc_pkg;

    localparam int OFF_W  = 13;
    localparam int SIG_W  = 2;
    localparam int IDX_W  = 3;
    localparam int SLEN_W = 4;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_FIND   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [SIG_W-1:0] SIG_JPEG = 2'd0;
    localparam logic [SIG_W-1:0] SIG_PNG  = 2'd1;
    localparam logic [SIG_W-1:0] SIG_PDF  = 2'd2;

    // byte 0 of each pattern in the lowest bits
    localparam logic [63:0] JPEG_HEAD = 64'h0000_0000_00FF_D8FF;
    localparam logic [63:0] JPEG_FOOT = 64'h0000_0000_0000_D9FF;
    localparam logic [63:0] PNG_HEAD  = 64'h0A1A_0A0D_474E_5089;
    localparam logic [63:0] PNG_FOOT  = 64'h8260_42AE_444E_4549;
    localparam logic [63:0] PDF_HEAD  = 64'h0000_002D_4644_5025;
    localparam logic [63:0] PDF_FOOT  = 64'h0000_0046_4F45_2525;

    typedef struct packed {
        logic             found;
        logic [SIG_W-1:0] sig;
    } hfsc_res_t;

    function automatic logic [SLEN_W-1:0] head_len(input logic [SIG_W-1:0] sig);
        logic [SLEN_W-1:0] len;
        case (sig)
            SIG_JPEG: len = 4'd3;
            SIG_PNG:  len = 4'd8;
            SIG_PDF:  len = 4'd5;
            default:  len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic [SLEN_W-1:0] foot_len(input logic [SIG_W-1:0] sig);
        logic [SLEN_W-1:0] len;
        case (sig)
            SIG_JPEG: len = 4'd2;
            SIG_PNG:  len = 4'd8;
            SIG_PDF:  len = 4'd5;
            default:  len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] head_byte(input logic [SIG_W-1:0] sig,
                                             input logic [IDX_W-1:0] idx);
        logic [63:0] pat;
        case (sig)
            SIG_JPEG: pat = JPEG_HEAD;
            SIG_PNG:  pat = PNG_HEAD;
            SIG_PDF:  pat = PDF_HEAD;
            default:  pat = 64'd0;
        endcase
        return pat[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] foot_byte(input logic [SIG_W-1:0] sig,
                                             input logic [IDX_W-1:0] idx);
        logic [63:0] pat;
        case (sig)
            SIG_JPEG: pat = JPEG_FOOT;
            SIG_PNG:  pat = PNG_FOOT;
            SIG_PDF:  pat = PDF_FOOT;
            default:  pat = 64'd0;
        endcase
        return pat[{idx, 3'b000} +: 8];
    endfunction

endpackage

[rtl/hfsc_ram.sv]
// ----------------------------------------------------------------------------
// hfsc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/hfsc_scan.sv]
// ----------------------------------------------------------------------------
// hfsc_scan
// scan sequencer: walks the buffer one byte compare at a time, header then
// footer search, with a per-signature footer cache for the current request
// ----------------------------------------------------------------------------
module hfsc_scan #(
    parameter int DEPTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [$clog2(DEPTH+1)-1:0]     start_pos,
    input  logic [$clog2(DEPTH+1)-1:0]     data_len,
    output logic [$clog2(DEPTH)-1:0]       rd_addr,
    input  logic [7:0]                     rd_data,
    output logic                           busy,
    output logic                           done,
    input  logic                           ack,
    output hfsc_pkg::hfsc_res_t            res,
    output logic [$clog2(DEPTH+1)-1:0]     res_start,
    output logic [$clog2(DEPTH+1)-1:0]     res_end
);
    import hfsc_pkg::*;

    localparam int LW  = $clog2(DEPTH + 1);
    localparam int AW  = $clog2(DEPTH);
    localparam int LW1 = LW + 1;
    localparam int NSIG = 3;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_POS    = 4'd1;
    localparam logic [3:0] ST_SIG    = 4'd2;
    localparam logic [3:0] ST_HRD    = 4'd3;
    localparam logic [3:0] ST_HCMP   = 4'd4;
    localparam logic [3:0] ST_FSTART = 4'd5;
    localparam logic [3:0] ST_FPOS   = 4'd6;
    localparam logic [3:0] ST_FRD    = 4'd7;
    localparam logic [3:0] ST_FCMP   = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [LW-1:0]    pos_reg, pos_next;
    logic [SIG_W-1:0] sig_reg, sig_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LW-1:0]    fp_reg, fp_next;
    logic             found_reg, found_next;
    logic [LW-1:0]    end_reg, end_next;

    // footer cache, one entry per signature
    logic          cv_reg [NSIG];
    logic          cv_next [NSIG];
    logic [LW-1:0] cfrom_reg [NSIG];
    logic [LW-1:0] cfrom_next [NSIG];
    logic          cfound_reg [NSIG];
    logic          cfound_next [NSIG];
    logic [LW-1:0] cq_reg [NSIG];
    logic [LW-1:0] cq_next [NSIG];

    logic [SLEN_W-1:0] hlen, flen, hlen_m1, flen_m1;
    logic [LW1-1:0]    hlen_x, flen_x, len_x;
    logic [LW1-1:0]    head_end, foot_end;
    logic [LW-1:0]     from_pos;
    logic [LW-1:0]     addr_sum;
    logic              hit;
    logic              adv;

    assign hlen    = head_len(sig_reg);
    assign flen    = foot_len(sig_reg);
    assign hlen_m1 = hlen - 4'd1;
    assign flen_m1 = flen - 4'd1;
    assign hlen_x  = {{(LW1-SLEN_W){1'b0}}, hlen};
    assign flen_x  = {{(LW1-SLEN_W){1'b0}}, flen};
    assign len_x   = {1'b0, data_len};
    assign head_end = {1'b0, pos_reg} + hlen_x;
    assign foot_end = {1'b0, fp_reg} + flen_x;
    assign from_pos = head_end[LW-1:0];

    // byte address unit shared by header and footer compares
    assign addr_sum = ((state_reg == ST_FRD) ? fp_reg : pos_reg)
                      + {{(LW-IDX_W){1'b0}}, idx_reg};
    assign rd_addr  = addr_sum[AW-1:0];

    assign hit = cv_reg[sig_reg] && (from_pos >= cfrom_reg[sig_reg])
                 && (!cfound_reg[sig_reg] || (from_pos <= cq_reg[sig_reg]));

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        sig_next    = sig_reg;
        idx_next    = idx_reg;
        fp_next     = fp_reg;
        found_next  = found_reg;
        end_next    = end_reg;
        cv_next     = cv_reg;
        cfrom_next  = cfrom_reg;
        cfound_next = cfound_reg;
        cq_next     = cq_reg;
        adv         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    pos_next = start_pos;
                    for (int i = 0; i < NSIG; i++) begin
                        cv_next[i] = 1'b0;
                    end
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                if (pos_reg >= data_len) begin
                    found_next = 1'b0;
                    end_next   = data_len;
                    state_next = ST_DONE;
                end else begin
                    sig_next   = SIG_JPEG;
                    state_next = ST_SIG;
                end
            end
            ST_SIG: begin
                if (head_end > len_x) begin
                    adv = 1'b1;
                end else begin
                    idx_next   = '0;
                    state_next = ST_HRD;
                end
            end
            ST_HRD: begin
                state_next = ST_HCMP;
            end
            ST_HCMP: begin
                if (rd_data == head_byte(sig_reg, idx_reg)) begin
                    if (idx_reg == hlen_m1[IDX_W-1:0]) begin
                        state_next = ST_FSTART;
                    end else begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_HRD;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            ST_FSTART: begin
                if ((from_pos >= data_len) || (flen_x > len_x)) begin
                    adv = 1'b1;
                end else if (hit) begin
                    if (cfound_reg[sig_reg]) begin
                        found_next = 1'b1;
                        end_next   = cq_reg[sig_reg] + {{(LW-SLEN_W){1'b0}}, flen};
                        state_next = ST_DONE;
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    fp_next    = from_pos;
                    state_next = ST_FPOS;
                end
            end
            ST_FPOS: begin
                if (foot_end > len_x) begin
                    cv_next[sig_reg]     = 1'b1;
                    cfrom_next[sig_reg]  = from_pos;
                    cfound_next[sig_reg] = 1'b0;
                    adv = 1'b1;
                end else begin
                    idx_next   = '0;
                    state_next = ST_FRD;
                end
            end
            ST_FRD: begin
                state_next = ST_FCMP;
            end
            ST_FCMP: begin
                if (rd_data == foot_byte(sig_reg, idx_reg)) begin
                    if (idx_reg == flen_m1[IDX_W-1:0]) begin
                        cv_next[sig_reg]     = 1'b1;
                        cfrom_next[sig_reg]  = from_pos;
                        cfound_next[sig_reg] = 1'b1;
                        cq_next[sig_reg]     = fp_reg;
                        found_next = 1'b1;
                        end_next   = foot_end[LW-1:0];
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_FRD;
                    end
                end else begin
                    fp_next    = fp_reg + 1'b1;
                    state_next = ST_FPOS;
                end
            end
            ST_DONE: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (adv) begin
            if (sig_reg == SIG_PDF) begin
                pos_next   = pos_reg + 1'b1;
                state_next = ST_POS;
            end else begin
                sig_next   = sig_reg + 2'd1;
                state_next = ST_SIG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NSIG; i++) begin
                cv_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            cv_reg    <= cv_next;
        end
        pos_reg    <= pos_next;
        sig_reg    <= sig_next;
        idx_reg    <= idx_next;
        fp_reg     <= fp_next;
        found_reg  <= found_next;
        end_reg    <= end_next;
        cfrom_reg  <= cfrom_next;
        cfound_reg <= cfound_next;
        cq_reg     <= cq_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign res.found = found_reg;
    assign res.sig   = sig_reg;
    assign res_start = pos_reg;
    assign res_end   = end_reg;

endmodule

[rtl/header_footer_signature_carver.sv]
// ----------------------------------------------------------------------------
// header_footer_signature_carver
// byte image buffer with header/footer signature carving
// ----------------------------------------------------------------------------
// input beats carry a command in s_tuser: append the byte in s_tdata, find the
// next fragment, or clear the buffer and scan position. append and clear beats
// give no result. a find beat gives exactly one result beat on the m_ channel:
// found flag and signature type in m_tuser, start and end offsets and the
// sticky overflow flag in m_tdata.
// a find walks the buffer through one ram read port: each byte compare has an
// address step, then a compare on the registered read data; footer searches
// are remembered per signature within one find.
// s_tready is low while a find is running or its result is waiting for the
// output register to free up.
// when the receiver stalls, the result beat is held in the output register
// and the next find result waits inside the sequencer.
// reset empties the buffer, zeroes the scan position and the overflow flag;
// buffer contents are not cleared, only the length is.
// ----------------------------------------------------------------------------
module header_footer_signature_carver #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // start_offset, end_offset, overflowed
    output logic [2:0]  m_tuser    // found, signature_type
);
    import hfsc_pkg::*;

    localparam int LW = $clog2(BUFFER_BYTES + 1);
    localparam int AW = $clog2(BUFFER_BYTES);

    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] scan_reg, scan_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_data_reg, m_data_next;
    logic [2:0]    m_user_reg, m_user_next;

    logic          accept;
    logic          full;
    logic          wr_en;
    logic          start;
    logic          busy, done, ack;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    hfsc_res_t     res;
    logic [LW-1:0] res_start, res_end;
    logic [OFF_W-1:0] start_off, end_off;

    assign accept = s_tvalid && s_tready;
    assign full   = (len_reg >= LW'(BUFFER_BYTES));
    assign wr_en  = accept && (s_tuser == MODE_APPEND) && !full;
    assign start  = accept && (s_tuser == MODE_FIND);
    assign ack    = !m_valid_reg || m_tready;
    assign s_tready = !busy;

    hfsc_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hfsc_scan #(
        .DEPTH (BUFFER_BYTES)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .start_pos (scan_reg),
        .data_len  (len_reg),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .busy      (busy),
        .done      (done),
        .ack       (ack),
        .res       (res),
        .res_start (res_start),
        .res_end   (res_end)
    );

    generate
        if (LW >= OFF_W) begin : g_trunc
            assign start_off = res_start[OFF_W-1:0];
            assign end_off   = res_end[OFF_W-1:0];
        end else begin : g_ext
            assign start_off = {{(OFF_W-LW){1'b0}}, res_start};
            assign end_off   = {{(OFF_W-LW){1'b0}}, res_end};
        end
    endgenerate

    always_comb begin
        len_next     = len_reg;
        scan_next    = scan_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            case (s_tuser)
                MODE_APPEND: begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        len_next = len_reg + 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    len_next  = '0;
                    scan_next = '0;
                end
                default: begin
                end
            endcase
        end
        if (done && ack) begin
            scan_next    = res_end;
            m_valid_next = 1'b1;
            if (res.found) begin
                m_data_next = {5'd0, ovf_reg, end_off, start_off};
                m_user_next = {res.sig, 1'b1};
            end else begin
                m_data_next = {5'd0, ovf_reg, {OFF_W{1'b0}}, {OFF_W{1'b0}}};
                m_user_next = {SIG_JPEG, 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            scan_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            scan_reg    <= scan_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

[test/tb_header_footer_signature_carver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_header_footer_signature_carver
// the carver is driven with append, find, clear and unused-mode beats. a
// scoreboard keeps its own image of the buffer and scan position, works out
// the fragment each find should report, and checks every result beat field by
// field. both sides stall at random, and the receiver holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_header_footer_signature_carver;
    import hfsc_pkg::*;

    localparam int BUF_BYTES   = 4096;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_NS    = 40_000_000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic             found;
        logic [SIG_W-1:0] sig;
        logic [OFF_W-1:0] first_off;
        logic [OFF_W-1:0] past_off;
        logic             ovf;
    } fragment_t;

    class carve_scoreboard;
        logic [7:0]  image [BUF_BYTES];
        int unsigned image_len;
        int unsigned scan_pos;
        bit          ovf_flag;
        fragment_t   pending [$];
        int          errors;

        function logic [63:0] hdr_pat(int s);
            case (s)
                SIG_JPEG: return JPEG_HEAD;
                SIG_PNG:  return PNG_HEAD;
                default:  return PDF_HEAD;
            endcase
        endfunction

        function logic [63:0] ftr_pat(int s);
            case (s)
                SIG_JPEG: return JPEG_FOOT;
                SIG_PNG:  return PNG_FOOT;
                default:  return PDF_FOOT;
            endcase
        endfunction

        function int hdr_len(int s);
            case (s)
                SIG_JPEG: return 3;
                SIG_PNG:  return 8;
                default:  return 5;
            endcase
        endfunction

        function int ftr_len(int s);
            case (s)
                SIG_JPEG: return 2;
                SIG_PNG:  return 8;
                default:  return 5;
            endcase
        endfunction

        function bit pattern_here(int unsigned p, logic [63:0] pat, int n);
            int i;
            if (p + n > image_len) return 1'b0;
            for (i = 0; i < n; i++) begin
                if (image[p + i] != pat[8*i +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pattern_next(int unsigned from, logic [63:0] pat, int n);
            int unsigned p;
            for (p = from; p + n <= image_len; p++) begin
                if (pattern_here(p, pat, n)) return p;
            end
            return -1;
        endfunction

        function void predict_fragment();
            fragment_t   r;
            int unsigned pos;
            int          s;
            int          foot;
            r = '0;
            r.ovf = ovf_flag;
            for (pos = scan_pos; pos < image_len; pos++) begin
                for (s = 0; s < 3; s++) begin
                    if (!pattern_here(pos, hdr_pat(s), hdr_len(s))) continue;
                    foot = pattern_next(pos + hdr_len(s), ftr_pat(s), ftr_len(s));
                    if (foot < 0) continue;
                    scan_pos    = foot + ftr_len(s);
                    r.found     = 1'b1;
                    r.sig       = s[SIG_W-1:0];
                    r.first_off = pos[OFF_W-1:0];
                    r.past_off  = scan_pos[OFF_W-1:0];
                    pending = {pending, r};
                    return;
                end
            end
            scan_pos = image_len;
            pending = {pending, r};
        endfunction

        function void note_input(logic [1:0] mode, logic [7:0] b);
            case (mode)
                MODE_APPEND: begin
                    if (image_len < BUF_BYTES) begin
                        image[image_len] = b;
                        image_len++;
                    end else begin
                        ovf_flag = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    image_len = 0;
                    scan_pos  = 0;
                end
                MODE_FIND: predict_fragment();
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) flag($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        function void check_result(logic [2:0] user, logic [31:0] data);
            fragment_t want;
            if (pending.size() == 0) begin
                flag($sformatf("result beat with nothing expected, tuser %h tdata %h",
                               user, data));
                return;
            end
            want = pending.pop_front();
            check_field("found", want.found, user[0]);
            check_field("signature_type", want.sig, user[2:1]);
            check_field("start_offset", want.first_off, data[12:0]);
            check_field("end_offset", want.past_off, data[25:13]);
            check_field("overflowed", want.ovf, data[26]);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte
    logic [1:0]  s_tuser;    // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // start_offset, end_offset, overflowed
    logic [2:0]  m_tuser;    // found, signature_type

    carve_scoreboard sb = new;
    bit no_gaps;
    bit hold_req;
    int gen_len;

    header_footer_signature_carver #(.BUFFER_BYTES(BUF_BYTES)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // never starts or ends a signature by accident
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == 8'hFF || b == 8'h89 || b == 8'h25 || b == 8'h49) b = b ^ 8'h01;
        return b;
    endfunction

    task automatic send_beat(input logic [1:0] mode, input logic [7:0] b);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) < 30) gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_pattern(input logic [63:0] pat, input int n);
        int i;
        for (i = 0; i < n; i++) send_beat(MODE_APPEND, pat[8*i +: 8]);
    endtask

    task automatic send_filler(input int n);
        int i;
        for (i = 0; i < n; i++) send_beat(MODE_APPEND, filler_byte());
    endtask

    task automatic random_section(input int n);
        int sent;
        int r;
        int t;
        int s;
        int k;
        int i;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (gen_len > 120 || r < 3) begin
                send_beat(MODE_CLEAR, 8'($urandom_range(0, 255)));
                gen_len = 0;
                sent++;
            end else if (r < 5) begin
                send_beat(MODE_UNUSED, 8'($urandom_range(0, 255)));
            end else if (r < 25) begin
                send_beat(MODE_FIND, 8'($urandom_range(0, 255)));
                sent++;
            end else begin
                t = $urandom_range(0, 9);
                s = $urandom_range(0, 2);
                case (t)
                    4, 5: begin
                        k = sb.hdr_len(s);
                        send_pattern(sb.hdr_pat(s), k);
                    end
                    6, 7: begin
                        k = sb.ftr_len(s);
                        send_pattern(sb.ftr_pat(s), k);
                    end
                    8: begin
                        k = $urandom_range(1, sb.hdr_len(s) - 1);
                        send_pattern(sb.hdr_pat(s), k);
                    end
                    9: begin
                        k = $urandom_range(1, sb.ftr_len(s) - 1);
                        send_pattern(sb.ftr_pat(s), k);
                    end
                    default: begin
                        k = $urandom_range(1, 6);
                        for (i = 0; i < k; i++)
                            send_beat(MODE_APPEND, 8'($urandom_range(0, 255)));
                    end
                endcase
                gen_len += k;
                sent    += k;
            end
        end
    endtask

    // receiver
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (no_gaps) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if ($urandom_range(0, 99) < 70) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                stall_left = pick_gap() - 1;
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_header_footer_signature_carver: FAIL");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = MODE_APPEND;
        no_gaps  = 1'b0;
        hold_req = 1'b0;
        gen_len  = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty buffer, unused mode
        send_beat(MODE_FIND, 8'hA5);
        send_beat(MODE_UNUSED, 8'h5A);
        // footer overlapping the header does not count
        send_pattern(64'h0000_0000_D9FF_D8FF, 4);
        send_beat(MODE_FIND, 8'h00);
        // scan resumes after the exhausted end, so the old header is not seen
        send_pattern(64'h0000_0000_00D9_FF00, 3);
        send_beat(MODE_FIND, 8'hFF);
        // clear, then header straight followed by footer
        send_beat(MODE_CLEAR, 8'h00);
        send_pattern(PDF_HEAD, 5);
        send_pattern(PDF_FOOT, 5);
        send_beat(MODE_FIND, 8'h00);
        gen_len = 10;

        random_section(160);

        // long receiver hold-off while finds keep coming
        send_beat(MODE_CLEAR, 8'h00);
        send_pattern(JPEG_HEAD, 3);
        send_pattern(JPEG_FOOT, 2);
        send_pattern(PNG_HEAD, 8);
        send_pattern(PNG_FOOT, 8);
        send_pattern(PDF_HEAD, 5);
        send_pattern(PDF_FOOT, 5);
        gen_len  = 31;
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        repeat (6) send_beat(MODE_FIND, 8'($urandom_range(0, 255)));

        random_section(60);
        no_gaps = 1'b0;
        random_section(100);

        // png fragment with filler between header and footer
        send_beat(MODE_CLEAR, 8'h00);
        send_pattern(PNG_HEAD, 8);
        send_filler(4);
        send_pattern(PNG_FOOT, 8);
        send_beat(MODE_FIND, 8'h00);
        send_beat(MODE_FIND, 8'h00);

        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_header_footer_signature_carver: PASS");
        else
            $display("tb_header_footer_signature_carver: FAIL");
        $finish;
    end

endmodule

[header_footer_signature_carver.f]
rtl/hfsc_pkg.sv
rtl/hfsc_ram.sv
rtl/hfsc_scan.sv
rtl/header_footer_signature_carver.sv
test/tb_header_footer_signature_carver.sv
